// ===== src/hmsc_pkg.sv =====
// ----------------------------------------------------------------------------
// hmsc_pkg
// Shared types and constants for the top-H magnitude sum check.
// ----------------------------------------------------------------------------
package hmsc_pkg;

	localparam int unsigned MAG_W   = 16;
	localparam int unsigned BOUND_W = 22;
	localparam int unsigned SUM_OUT_W = 21;
	localparam int unsigned OUT_TDATA_W = 24;
	localparam int unsigned CMP_W   = 25;
	localparam logic [CMP_W-1:0] SUM_OUT_MAX = CMP_W'(2097151);

	typedef logic [MAG_W-1:0] mag_t;

	typedef struct packed {
		logic ins;
		logic shift;
	} cell_ctl_t;

endpackage

// ===== src/hmsc_cell.sv =====
// ----------------------------------------------------------------------------
// hmsc_cell
// One slot of the sorted magnitude chain: insert from the broadcast value or
// the left neighbor, or shift the left neighbor in while draining.
// ----------------------------------------------------------------------------
module hmsc_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  hmsc_pkg::cell_ctl_t ctl,
	input  hmsc_pkg::mag_t     mag,
	input  hmsc_pkg::mag_t     left_val,
	input  logic               left_gt,
	output hmsc_pkg::mag_t     val,
	output logic               gt
);

	hmsc_pkg::mag_t val_q;

	assign val = val_q;
	assign gt  = mag > val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
		end else if (ctl.shift) begin
			val_q <= left_val;
		end else if (ctl.ins && gt) begin
			val_q <= left_gt ? left_val : mag;
		end
	end

endmodule

// ===== src/top_h_magnitude_sum_check.sv =====
// ----------------------------------------------------------------------------
// top_h_magnitude_sum_check
// Keeps the TOP_COUNT largest coefficient magnitudes of a polynomial in a
// sorted chain of cells and, after the last word, sums them and checks the bound.
//
//  channel | dir | fields
//  s_*     | in  | tdata[15:0] coefficient, tlast last_coefficient
//  m_*     | out | tdata[20:0] magnitude_sum, tuser[0] rejected
//  cfg_*   | in  | cfg_data[21:0] sum_bound, written when cfg_we is high
//
// One coefficient per cycle is taken while a polynomial streams in.
// After the last word the chain drains into the adder, and then the result
// is loaded into the output register; s_tready is low for that time.
// The drain shifts zeros in, so the store is clear for the next polynomial.
// A pending result holds the load step until m_tready; reset empties the store.
// ----------------------------------------------------------------------------
module top_h_magnitude_sum_check #(
	parameter int unsigned TOP_COUNT = 40
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // coefficient
	input  logic        s_tlast,   // last_coefficient
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // magnitude_sum, zero pad
	output logic [0:0]  m_tuser,   // rejected
	input  logic        cfg_we,
	input  logic [21:0] cfg_data
);

	localparam int unsigned SUM_W = hmsc_pkg::MAG_W + $clog2(TOP_COUNT + 1);
	localparam int unsigned CNT_W = $clog2(TOP_COUNT + 1);

	typedef enum logic [1:0] {RUN, DRAIN, FINISH} state_t;

	state_t                           state_q;
	logic [CNT_W-1:0]                 cnt_q;
	logic [SUM_W-1:0]                 acc_q;
	logic [hmsc_pkg::BOUND_W-1:0]     bound_q;
	logic                             m_valid_q;
	logic [hmsc_pkg::SUM_OUT_W-1:0]   sum_q;
	logic                             rej_q;

	hmsc_pkg::mag_t                   mag;
	hmsc_pkg::cell_ctl_t              ctl;
	hmsc_pkg::mag_t                   val_w [TOP_COUNT];
	logic                             gt_w  [TOP_COUNT];
	logic                             in_acc;
	logic [hmsc_pkg::CMP_W-1:0]       acc_ext;

	assign s_tready = (state_q == RUN);
	assign in_acc   = s_tvalid && s_tready;
	assign mag      = s_tdata[15] ? (~s_tdata + 16'd1) : s_tdata;
	assign ctl.ins   = in_acc;
	assign ctl.shift = (state_q == DRAIN);
	assign acc_ext  = hmsc_pkg::CMP_W'(acc_q);

	for (genvar i = 0; i < TOP_COUNT; i++) begin : g_cell
		if (i == 0) begin : g_head
			hmsc_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctl      (ctl),
				.mag      (mag),
				.left_val ('0),
				.left_gt  (1'b0),
				.val      (val_w[i]),
				.gt       (gt_w[i])
			);
		end else begin : g_body
			hmsc_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctl      (ctl),
				.mag      (mag),
				.left_val (val_w[i-1]),
				.left_gt  (gt_w[i-1]),
				.val      (val_w[i]),
				.gt       (gt_w[i])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bound_q <= '0;
		end else if (cfg_we) begin
			bound_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= RUN;
			cnt_q     <= '0;
			acc_q     <= '0;
			m_valid_q <= 1'b0;
			sum_q     <= '0;
			rej_q     <= 1'b0;
		end else begin
			if (state_q == FINISH && (!m_valid_q || m_tready)) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				RUN: begin
					if (in_acc && s_tlast) begin
						state_q <= DRAIN;
						cnt_q   <= '0;
						acc_q   <= '0;
					end
				end
				DRAIN: begin
					acc_q <= acc_q + SUM_W'(val_w[TOP_COUNT-1]);
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(TOP_COUNT - 1)) begin
						state_q <= FINISH;
					end
				end
				FINISH: begin
					if (!m_valid_q || m_tready) begin
						sum_q     <= (acc_ext > hmsc_pkg::SUM_OUT_MAX) ?
							hmsc_pkg::SUM_OUT_W'(hmsc_pkg::SUM_OUT_MAX) :
							hmsc_pkg::SUM_OUT_W'(acc_ext);
						rej_q     <= acc_ext > hmsc_pkg::CMP_W'(bound_q);
						state_q   <= RUN;
					end
				end
				default: state_q <= RUN;
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = hmsc_pkg::OUT_TDATA_W'(sum_q);
	assign m_tuser  = rej_q;

endmodule

// ===== src/hmsc_checker.sv =====
// ----------------------------------------------------------------------------
// hmsc_checker
// Port-level checks for the top-H magnitude sum check, bound to the top level.
// ----------------------------------------------------------------------------
module hmsc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic [0:0]  m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word dropped or changed while stalled");

	a_last_stall: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("input taken during drain");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[23:21] == 3'd0)
		else $error("result pad bits not zero");

	a_result_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared without a drain");

endmodule

bind top_h_magnitude_sum_check hmsc_checker u_hmsc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
